// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks of the failsafe block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while the given reset is low
`define CSF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset
`define CSF_ASSERT(lbl, prop, msg) \
  `CSF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg
// Types, codes and constants shared by the command sequence failsafe block.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

  // Number of driven outputs; mask state is this wide
  localparam int unsigned OutputCount = 6;
  // Width of the mask fields on the result channel
  localparam int unsigned MaskFieldW  = 6;

  localparam logic [15:0] FailsafeTimeoutRst = 16'd1000;
  localparam logic [15:0] LinkLostRst        = 16'd1500;

  typedef logic [OutputCount-1:0] out_mask_t;

  typedef enum logic [1:0] {
    CmdCommand = 2'd0,
    CmdTick    = 2'd1,
    CmdFault   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CfgFailsafeTimeout = 2'd0,
    CfgLinkLost        = 2'd1,
    CfgActiveLow       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [15:0] sequence_req;
    logic [7:0]  requested_mask;
  } item_t;

  typedef struct packed {
    logic                  ack_send;
    logic [15:0]           ack_sequence;
    logic [MaskFieldW-1:0] applied_mask;
    logic [MaskFieldW-1:0] pin_levels;
    logic [31:0]           mask_generation;
    logic                  failsafe_on;
    logic                  link_up;
    logic [31:0]           link_age_ms;
    logic [31:0]           accepted_count;
    logic [31:0]           fault_count;
  } result_t;

  typedef struct packed {
    logic [15:0] failsafe_timeout_ms;
    logic [15:0] link_limit_ms;
    logic        outputs_active_low;
  } cfg_t;

  // Place an output mask into the result field, zero-extended or cut
  function automatic logic [MaskFieldW-1:0] mask_to_field(input out_mask_t m);
    logic [15:0] w;
    w = 16'(m);
    return w[MaskFieldW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csf_intf.sv =====
// ----------------------------------------------------------------------------
// csf_intf
// Valid/ready channels of the failsafe block: events, results, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface csf_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] now_ms;
  logic [15:0] sequence_req;
  logic [7:0]  requested_mask;

  modport source (output valid, cmd, now_ms, sequence_req, requested_mask, input ready);
  modport sink   (input valid, cmd, now_ms, sequence_req, requested_mask, output ready);
endinterface

interface csf_res_if;
  logic                           valid;
  logic                           ready;
  logic                           ack_send;
  logic [15:0]                    ack_sequence;
  logic [csf_pkg::MaskFieldW-1:0] applied_mask;
  logic [csf_pkg::MaskFieldW-1:0] pin_levels;
  logic [31:0]                    mask_generation;
  logic                           failsafe_on;
  logic                           link_up;
  logic [31:0]                    link_age_ms;
  logic [31:0]                    accepted_count;
  logic [31:0]                    fault_count;

  modport source (output valid, ack_send, ack_sequence, applied_mask, pin_levels,
                  mask_generation, failsafe_on, link_up, link_age_ms,
                  accepted_count, fault_count, input ready);
  modport sink   (input valid, ack_send, ack_sequence, applied_mask, pin_levels,
                  mask_generation, failsafe_on, link_up, link_age_ms,
                  accepted_count, fault_count, output ready);
endinterface

interface csf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csf_cfg_regs
// Configuration registers: timeout, link-lost limit and pin polarity.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  logic [1:0]    wr_index_i,
  input  logic [15:0]   wr_data_i,
  output logic          wr_ready_o,
  output csf_pkg::cfg_t cfg_o
);

  csf_pkg::cfg_t cfg_d, cfg_q;

  // Take every write at once
  assign wr_ready_o = 1'b1;

  // Decode the register index; unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (csf_pkg::cfg_idx_e'(wr_index_i))
        csf_pkg::CfgFailsafeTimeout: cfg_d.failsafe_timeout_ms = wr_data_i;
        csf_pkg::CfgLinkLost:        cfg_d.link_limit_ms       = wr_data_i;
        csf_pkg::CfgActiveLow:       cfg_d.outputs_active_low  = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failsafe_timeout_ms <= csf_pkg::FailsafeTimeoutRst;
      cfg_q.link_limit_ms       <= csf_pkg::LinkLostRst;
      cfg_q.outputs_active_low  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/csf_in_stage.sv =====
// ----------------------------------------------------------------------------
// csf_in_stage
// Input register: holds one event until the result side can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  csf_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           out_free_i,
  output logic           advance_o,
  output csf_pkg::item_t item_o
);

  logic           valid_d, valid_q;
  csf_pkg::item_t item_q;

  // Accept when empty or when the held event moves on this cycle
  assign ready_o   = !valid_q || out_free_i;
  assign advance_o = valid_q && out_free_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload of each transaction
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/csf_core.sv =====
// ----------------------------------------------------------------------------
// csf_core
// Sequence check, mask and failsafe state, counters and status for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  csf_pkg::item_t   item_i,
  input  csf_pkg::cfg_t    cfg_i,
  output csf_pkg::result_t result_o
);

  csf_pkg::out_mask_t mask_d, mask_q;
  logic [31:0]        gen_d, gen_q;
  logic [31:0]        last_time_d, last_time_q;
  logic [31:0]        cmd_count_d, cmd_count_q;
  logic [31:0]        fault_count_d, fault_count_q;
  logic               seen_cmd_d, seen_cmd_q;
  logic               seen_seq_d, seen_seq_q;
  logic               tripped_d, tripped_q;
  logic [15:0]        newest_seq_d, newest_seq_q;

  logic [31:0]        elapsed;
  logic               over_limit;
  logic [15:0]        seq_diff;
  logic               seq_ahead;
  logic               is_new;
  logic               is_dup;
  logic               cmd_take;
  logic               mask_set;
  csf_pkg::out_mask_t mask_req;
  logic [31:0]        age;
  csf_pkg::out_mask_t pins;

  // Time since the last command and sequence distance
  assign elapsed    = item_i.now_ms - last_time_q;
  assign over_limit = elapsed > {16'd0, cfg_i.failsafe_timeout_ms};
  assign seq_diff   = item_i.sequence_req - newest_seq_q;
  assign seq_ahead  = (seq_diff != 16'd0) && !seq_diff[15];
  assign is_new     = !seen_seq_q || !seen_cmd_q || over_limit || seq_ahead;
  assign is_dup     = seen_seq_q && (item_i.sequence_req == newest_seq_q);

  // Next state for the event
  always_comb begin
    mask_d        = mask_q;
    gen_d         = gen_q;
    last_time_d   = last_time_q;
    cmd_count_d   = cmd_count_q;
    fault_count_d = fault_count_q;
    seen_cmd_d    = seen_cmd_q;
    seen_seq_d    = seen_seq_q;
    tripped_d     = tripped_q;
    newest_seq_d  = newest_seq_q;
    cmd_take      = 1'b0;
    mask_set      = 1'b0;
    mask_req      = '0;

    case (csf_pkg::cmd_e'(item_i.cmd))
      csf_pkg::CmdCommand: begin
        if (is_new || is_dup) begin
          cmd_take    = 1'b1;
          cmd_count_d = cmd_count_q + 32'd1;
          last_time_d = item_i.now_ms;
          seen_cmd_d  = 1'b1;
          tripped_d   = 1'b0;
          if (is_new) begin
            mask_set     = 1'b1;
            mask_req     = csf_pkg::out_mask_t'(item_i.requested_mask);
            newest_seq_d = item_i.sequence_req;
            seen_seq_d   = 1'b1;
          end
        end
      end
      csf_pkg::CmdTick: begin
        if (seen_cmd_q && !tripped_q && over_limit) begin
          mask_set  = 1'b1;
          tripped_d = 1'b1;
        end
      end
      csf_pkg::CmdFault: begin
        fault_count_d = fault_count_q + 32'd1;
      end
      default: ;
    endcase

    // Bump the generation only on a real change
    if (mask_set && (mask_req != mask_q)) begin
      mask_d = mask_req;
      gen_d  = gen_q + 32'd1;
    end
  end

  // Status against this event's time; a taken command resets the age
  always_comb begin
    if (!seen_cmd_d) begin
      age = '1;
    end else if (cmd_take) begin
      age = '0;
    end else begin
      age = elapsed;
    end
  end

  assign pins = cfg_i.outputs_active_low ? ~mask_d : mask_d;

  always_comb begin
    result_o.ack_send        = cmd_take;
    result_o.ack_sequence    = cmd_take ? item_i.sequence_req : 16'd0;
    result_o.applied_mask    = csf_pkg::mask_to_field(mask_d);
    result_o.pin_levels      = csf_pkg::mask_to_field(pins);
    result_o.mask_generation = gen_d;
    result_o.failsafe_on     = tripped_d;
    result_o.link_up         = seen_cmd_d && (age < {16'd0, cfg_i.link_limit_ms});
    result_o.link_age_ms     = age;
    result_o.accepted_count  = cmd_count_d;
    result_o.fault_count     = fault_count_d;
  end

  // Commit state when the event moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q        <= '0;
      gen_q         <= '0;
      last_time_q   <= '0;
      cmd_count_q   <= '0;
      fault_count_q <= '0;
      seen_cmd_q    <= 1'b0;
      seen_seq_q    <= 1'b0;
      tripped_q     <= 1'b0;
      newest_seq_q  <= '0;
    end else if (advance_i) begin
      mask_q        <= mask_d;
      gen_q         <= gen_d;
      last_time_q   <= last_time_d;
      cmd_count_q   <= cmd_count_d;
      fault_count_q <= fault_count_d;
      seen_cmd_q    <= seen_cmd_d;
      seen_seq_q    <= seen_seq_d;
      tripped_q     <= tripped_d;
      newest_seq_q  <= newest_seq_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csf_out_stage.sv =====
// ----------------------------------------------------------------------------
// csf_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  csf_pkg::result_t result_i,
  input  logic             ready_i,
  output logic             valid_o,
  output logic             free_o,
  output csf_pkg::result_t result_o
);

  logic             valid_d, valid_q;
  csf_pkg::result_t result_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/command_sequence_failsafe.sv =====
// ----------------------------------------------------------------------------
// command_sequence_failsafe
// Sequence-checked output commands with a timeout failsafe and link status.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload
//   evt_i     in    cmd, now_ms, sequence_req, requested_mask
//   res_o     out   ack/sequence, mask, pins, generation, failsafe, link, counts
//   cfg_i     in    index, data (timeout, link-lost limit, active-low pins)
//
// One event per cycle unless the result stalls; each yields exactly one result.
// An event moves from the input register into the result register; the
// sequence check and state update sit between the two.
// Reset clears valid flags and core state, loads register defaults; no warm-up.
// A stalled result holds the event in the input register, then evt_i.ready
// drops; config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module command_sequence_failsafe (
  input  logic      clk_i,
  input  logic      rst_ni,
  csf_evt_if.sink   evt_i,
  csf_res_if.source res_o,
  csf_cfg_if.sink   cfg_i
);

  csf_pkg::item_t   evt_item;
  csf_pkg::item_t   held_item;
  csf_pkg::cfg_t    cfg;
  csf_pkg::result_t next_result;
  csf_pkg::result_t res_q;
  logic             advance;
  logic             out_free;

  // Gather the event fields
  assign evt_item.cmd            = evt_i.cmd;
  assign evt_item.now_ms         = evt_i.now_ms;
  assign evt_item.sequence_req   = evt_i.sequence_req;
  assign evt_item.requested_mask = evt_i.requested_mask;

  csf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  csf_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (evt_i.valid),
    .item_i     (evt_item),
    .ready_o    (evt_i.ready),
    .out_free_i (out_free),
    .advance_o  (advance),
    .item_o     (held_item)
  );

  csf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .cfg_i     (cfg),
    .result_o  (next_result)
  );

  csf_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (next_result),
    .ready_i  (res_o.ready),
    .valid_o  (res_o.valid),
    .free_o   (out_free),
    .result_o (res_q)
  );

  // Drive the result fields
  assign res_o.ack_send        = res_q.ack_send;
  assign res_o.ack_sequence    = res_q.ack_sequence;
  assign res_o.applied_mask    = res_q.applied_mask;
  assign res_o.pin_levels      = res_q.pin_levels;
  assign res_o.mask_generation = res_q.mask_generation;
  assign res_o.failsafe_on     = res_q.failsafe_on;
  assign res_o.link_up         = res_q.link_up;
  assign res_o.link_age_ms     = res_q.link_age_ms;
  assign res_o.accepted_count  = res_q.accepted_count;
  assign res_o.fault_count     = res_q.fault_count;

  // Checks
  `CSF_ASSERT(a_no_overwrite, res_o.valid && !res_o.ready |-> !advance, "pending result overwritten")
  `CSF_ASSERT(a_advance_loads, advance |=> res_o.valid, "moved event left no result")
  `CSF_ASSERT(a_failsafe_off, res_o.valid && res_o.failsafe_on |-> (res_o.applied_mask == '0) && !res_o.ack_send, "failsafe with outputs on")

endmodule

`default_nettype wire
